// ----- rtl/keyed_best_score_ranked_table_macros.svh -----
// Assertion macros used by the ranked table checker.
`ifndef KEYED_BEST_SCORE_RANKED_TABLE_MACROS_SVH
`define KEYED_BEST_SCORE_RANKED_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KBSRT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KBSRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/kbsrt_pkg.sv -----
// Shared types and constants of the keyed best-score ranked table.
package kbsrt_pkg;

   localparam int KEY_W      = 32;
   localparam int IN_SCORE_W = 32;
   localparam int POS_W      = 6;
   localparam int RANK_W     = 7;
   localparam int COUNT_W    = 7;
   localparam int CFG_W      = 7;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [1:0] {
      ACT_SUBMIT = 2'd0,
      ACT_QUERY  = 2'd1,
      ACT_READ   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_DROPPED   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HIGHER_IS_BETTER = 2'd0,
      CSR_MAX_ENTRIES      = 2'd1,
      CSR_NOTIFY_TOP_N     = 2'd2
   } csr_index_type;

   // How the cell row moves on a committed submit
   typedef enum logic [1:0] {
      SHIFT_NONE  = 2'd0,
      SHIFT_FRESH = 2'd1,
      SHIFT_MOVE  = 2'd2
   } shift_mode_type;

   typedef struct packed {
      logic           eval_en;
      logic           commit_en;
      logic           by_position;
      logic           higher_is_better;
      shift_mode_type mode;
   } cell_ctrl_type;

endpackage

// ----- rtl/kbsrt_req_if.sv -----
// Request channel: action, player key, score and table position.
interface kbsrt_req_if;
   import kbsrt_pkg::*;

   logic                          valid;
   logic                          ready;
   action_type                    action;
   logic [KEY_W-1:0]              player_key;
   logic signed [IN_SCORE_W-1:0]  new_score;
   logic [POS_W-1:0]              position;

   modport source (output valid, action, player_key, new_score, position, input ready);
   modport sink   (input valid, action, player_key, new_score, position, output ready);
endinterface

// ----- rtl/kbsrt_rsp_if.sv -----
// Response channel: one result per request.
interface kbsrt_rsp_if;
   import kbsrt_pkg::*;

   logic                          valid;
   logic                          ready;
   status_type                    status;
   logic [RANK_W-1:0]             rank_out;
   logic [KEY_W-1:0]              key_out;
   logic signed [IN_SCORE_W-1:0]  score_out;
   logic                          notify;
   logic [COUNT_W-1:0]            entry_count;

   modport source (output valid, status, rank_out, key_out, score_out, notify, entry_count,
                   input ready);
   modport sink   (input valid, status, rank_out, key_out, score_out, notify, entry_count,
                   output ready);
endinterface

// ----- rtl/kbsrt_csr_if.sv -----
// Configuration write channel: register index and write data.
interface kbsrt_csr_if;
   import kbsrt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CFG_W-1:0]      wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/kbsrt_cell.sv -----
// One table slot: holds a key and score, compares against the broadcast item, shifts.
module kbsrt_cell #(
   parameter int IDX        = 0,
   parameter int CAPACITY   = 64,
   parameter int SCORE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  kbsrt_pkg::cell_ctrl_type               ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0]          held_count,
   input  logic [$clog2(CAPACITY)-1:0]            m_idx,
   input  logic [kbsrt_pkg::KEY_W-1:0]            item_key,
   input  logic signed [SCORE_BITS-1:0]           item_score,
   input  logic [kbsrt_pkg::POS_W-1:0]            position,
   input  logic [kbsrt_pkg::KEY_W-1:0]            left_key,
   input  logic signed [SCORE_BITS-1:0]           left_score,
   input  logic                                   left_beat,
   output logic [kbsrt_pkg::KEY_W-1:0]            entry_key,
   output logic signed [SCORE_BITS-1:0]           entry_score,
   output logic                                   beat,
   output logic                                   match,
   output logic                                   improve,
   output logic                                   sel,
   output logic                                   at_p
);
   import kbsrt_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic [KEY_W-1:0]        key_ff, key_in;
   logic signed [SCORE_BITS-1:0] score_ff, score_in;
   logic                    beat_ff, beat_in;
   logic                    held;
   logic                    beats;

   // compare the held entry against the broadcast item
   always_comb begin
      held    = MY_POS < held_count;
      beats   = ctrl.higher_is_better ? (item_score > score_ff) : (item_score < score_ff);
      match   = held && (key_ff == item_key);
      improve = match && beats;
      sel     = ctrl.by_position ? (held && (int'(position) == IDX)) : match;
      at_p    = beat_ff && !left_beat;
   end

   // capture the beat flag; empty slots always count as beaten
   assign beat_in = ctrl.eval_en ? (held ? beats : 1'b1) : beat_ff;

   // take the item at the insertion point, take the left neighbor behind it (on a move, only up to the old slot)
   always_comb begin
      key_in   = key_ff;
      score_in = score_ff;
      if (ctrl.commit_en) begin
         unique case (ctrl.mode)
            SHIFT_FRESH: begin
               if (at_p) begin
                  key_in   = item_key;
                  score_in = item_score;
               end else if (left_beat) begin
                  key_in   = left_key;
                  score_in = left_score;
               end
            end
            SHIFT_MOVE: begin
               if (at_p) begin
                  key_in   = item_key;
                  score_in = item_score;
               end else if (left_beat && (MY_IDX <= m_idx)) begin
                  key_in   = left_key;
                  score_in = left_score;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      score_ff <= score_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= 1'b0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   assign entry_key   = key_ff;
   assign entry_score = score_ff;
   assign beat        = beat_ff;

endmodule

// ----- rtl/keyed_best_score_ranked_table.sv -----
// Top level of the keyed best-score ranked table: control, gather and cell row.
//
// Usage:
//   req_chan carries one action per transfer: submit a score for a player key,
//   query the rank of a key, read the entry at a table position, or clear.
//   rsp_chan returns exactly one result per request, in order.
//   csr_chan writes higher_is_better (0), max_entries (1), notify_top_n (2);
//   write it only while no request is in flight.
// Timing:
//   A request passes through an evaluate state, in which every cell compares
//   against it, then an update state, in which the cell row shifts and the
//   result register loads once the output register is free. The next request
//   is taken in the cycle the result loads, so a new request is accepted while
//   the last one completes, as long as the receiver keeps up; the broadcast
//   compare followed by the neighbor shift of the cell row sets the pace.
// Reset: the table is empty, higher_is_better=1, max_entries=64,
//   notify_top_n=0. No clearing pass is needed; slots past the fill count are
//   never read.
// Stall: a result not taken holds in the output register; one further request
//   may be taken and waits after its compare until the register frees.
module keyed_best_score_ranked_table #(
   parameter int CAPACITY   = 64,
   parameter int SCORE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   kbsrt_req_if.sink   req_chan,
   kbsrt_rsp_if.source rsp_chan,
   kbsrt_csr_if.sink   csr_chan
);
   import kbsrt_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EVAL   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // request holding registers
   action_type                   act_ff;
   logic [KEY_W-1:0]             key_ff;
   logic signed [SCORE_BITS-1:0] score_ff;
   logic [POS_W-1:0]             pos_ff;
   logic signed [SCORE_BITS-1:0] stored_score;

   // configuration and fill count
   logic             hib_ff;
   logic [CFG_W-1:0] max_entries_ff;
   logic [CFG_W-1:0] notify_top_n_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   // gathered compare results
   logic                         found_ff, improved_ff, sel_hit_ff;
   logic [IDX_W-1:0]             m_idx_ff;
   logic [KEY_W-1:0]             sel_key_ff;
   logic signed [SCORE_BITS-1:0] sel_score_ff;
   logic                         g_found, g_improved, g_hit;
   logic [IDX_W-1:0]             g_m;
   logic [KEY_W-1:0]             g_key;
   logic signed [SCORE_BITS-1:0] g_score;
   logic                         p_hit;
   logic [IDX_W-1:0]             p_idx;

   // response register
   logic                         rsp_valid_ff;
   status_type                   status_ff, status_in;
   logic [RANK_W-1:0]            rank_ff, rank_in;
   logic [KEY_W-1:0]             key_out_ff, key_out_in;
   logic signed [IN_SCORE_W-1:0] score_out_ff, score_out_in;
   logic                         notify_ff, notify_in;
   logic [COUNT_W-1:0]           count_out_ff, count_out_in;

   // cell row wiring
   logic [KEY_W-1:0]             cell_key   [CAPACITY];
   logic signed [SCORE_BITS-1:0] cell_score [CAPACITY];
   logic                         cell_beat  [CAPACITY];
   logic                         cell_match [CAPACITY];
   logic                         cell_impr  [CAPACITY];
   logic                         cell_sel   [CAPACITY];
   logic                         cell_at_p  [CAPACITY];
   logic [KEY_W-1:0]             left_key   [CAPACITY];
   logic signed [SCORE_BITS-1:0] left_score [CAPACITY];
   logic                         left_beat  [CAPACITY];

   cell_ctrl_type  ctrl;
   shift_mode_type mode;
   logic           req_ready, req_fire, commit;

   // submit bookkeeping
   logic [CNT_W-1:0] p_full, p_eff, limit, grown, trimmed, rank_full, rank_q;
   logic             dropped, notify_hit;

   // handshakes
   assign commit    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign req_fire  = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   // saturate the incoming score to the stored width
   generate
      if (SCORE_BITS >= IN_SCORE_W) begin : g_score_wide
         assign stored_score = SCORE_BITS'(req_chan.new_score);
      end else begin : g_score_narrow
         localparam longint SAT_HI = (longint'(1) << (SCORE_BITS-1)) - longint'(1);
         localparam longint SAT_LO = -SAT_HI - longint'(1);
         always_comb begin
            if (longint'(req_chan.new_score) > SAT_HI) begin
               stored_score = SCORE_BITS'(SAT_HI);
            end else if (longint'(req_chan.new_score) < SAT_LO) begin
               stored_score = SCORE_BITS'(SAT_LO);
            end else begin
               stored_score = SCORE_BITS'(req_chan.new_score);
            end
         end
      end
   endgenerate

   // latch the request on transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff   <= req_chan.action;
         key_ff   <= req_chan.player_key;
         score_ff <= stored_score;
         pos_ff   <= req_chan.position;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_UPDATE;
         ST_UPDATE: if (commit) state_in = req_fire ? ST_EVAL : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hib_ff          <= 1'b1;
         max_entries_ff  <= CFG_W'(64);
         notify_top_n_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CSR_HIGHER_IS_BETTER: hib_ff          <= csr_chan.wdata[0];
            CSR_MAX_ENTRIES:      max_entries_ff  <= csr_chan.wdata;
            CSR_NOTIFY_TOP_N:     notify_top_n_ff <= csr_chan.wdata;
            default: begin
            end
         endcase
      end
   end

   // pick the shift for this request
   always_comb begin
      if (act_ff != ACT_SUBMIT) begin
         mode = SHIFT_NONE;
      end else if (!found_ff) begin
         mode = SHIFT_FRESH;
      end else if (improved_ff) begin
         mode = SHIFT_MOVE;
      end else begin
         mode = SHIFT_NONE;
      end
   end

   assign ctrl.eval_en          = (state_ff == ST_EVAL);
   assign ctrl.commit_en        = commit;
   assign ctrl.by_position      = (act_ff == ACT_READ);
   assign ctrl.higher_is_better = hib_ff;
   assign ctrl.mode             = mode;

   // cell row
   generate
      for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
         if (j == 0) begin : g_head
            assign left_key[j]   = '0;
            assign left_score[j] = '0;
            assign left_beat[j]  = 1'b0;
         end else begin : g_link
            assign left_key[j]   = cell_key[j-1];
            assign left_score[j] = cell_score[j-1];
            assign left_beat[j]  = cell_beat[j-1];
         end

         kbsrt_cell #(
            .IDX        (j),
            .CAPACITY   (CAPACITY),
            .SCORE_BITS (SCORE_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .held_count  (count_ff),
            .m_idx       (m_idx_ff),
            .item_key    (key_ff),
            .item_score  (score_ff),
            .position    (pos_ff),
            .left_key    (left_key[j]),
            .left_score  (left_score[j]),
            .left_beat   (left_beat[j]),
            .entry_key   (cell_key[j]),
            .entry_score (cell_score[j]),
            .beat        (cell_beat[j]),
            .match       (cell_match[j]),
            .improve     (cell_impr[j]),
            .sel         (cell_sel[j]),
            .at_p        (cell_at_p[j])
         );
      end
   endgenerate

   // OR-gather the one-hot cell flags and selected entry
   always_comb begin
      g_found    = 1'b0;
      g_improved = 1'b0;
      g_hit      = 1'b0;
      g_m        = '0;
      g_key      = '0;
      g_score    = '0;
      p_hit      = 1'b0;
      p_idx      = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         if (cell_match[j]) begin
            g_found = 1'b1;
            g_m     = g_m | IDX_W'(j);
         end
         if (cell_impr[j]) begin
            g_improved = 1'b1;
         end
         if (cell_sel[j]) begin
            g_hit   = 1'b1;
            g_key   = g_key | cell_key[j];
            g_score = g_score | cell_score[j];
         end
         if (cell_at_p[j]) begin
            p_hit = 1'b1;
            p_idx = p_idx | IDX_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL) begin
         found_ff     <= g_found;
         improved_ff  <= g_improved;
         sel_hit_ff   <= g_hit;
         m_idx_ff     <= g_m;
         sel_key_ff   <= g_key;
         sel_score_ff <= g_score;
      end
   end

   // insertion point, fill count after insert and trim
   always_comb begin
      p_full  = p_hit ? CNT_W'(p_idx) : CNT_W'(CAPACITY);
      p_eff   = (mode == SHIFT_NONE) ? CNT_W'(m_idx_ff) : p_full;
      limit   = (LIM_W'(max_entries_ff) > LIM_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                            : CNT_W'(max_entries_ff);
      grown   = (mode == SHIFT_FRESH && p_hit && count_ff != CNT_W'(CAPACITY))
                ? count_ff + CNT_W'(1) : count_ff;
      trimmed = (grown > limit) ? limit : grown;
      dropped = (p_eff >= trimmed);
      rank_full  = p_eff + CNT_W'(1);
      rank_q     = CNT_W'(m_idx_ff) + CNT_W'(1);
      notify_hit = (mode == SHIFT_FRESH) && !dropped
                   && (LIM_W'(rank_full) <= LIM_W'(notify_top_n_ff));
   end

   // build the result
   always_comb begin
      status_in    = STAT_OK;
      rank_in      = '0;
      key_out_in   = '0;
      score_out_in = '0;
      notify_in    = 1'b0;
      count_in     = count_ff;
      unique case (act_ff)
         ACT_SUBMIT: begin
            key_out_in = key_ff;
            count_in   = trimmed;
            if (dropped) begin
               status_in    = STAT_DROPPED;
               score_out_in = IN_SCORE_W'(score_ff);
            end else begin
               rank_in      = RANK_W'(rank_full);
               score_out_in = (mode == SHIFT_NONE) ? IN_SCORE_W'(sel_score_ff)
                                                   : IN_SCORE_W'(score_ff);
               notify_in    = notify_hit;
            end
         end
         ACT_QUERY: begin
            key_out_in = key_ff;
            if (found_ff) begin
               rank_in      = RANK_W'(rank_q);
               score_out_in = IN_SCORE_W'(sel_score_ff);
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         ACT_READ: begin
            if (sel_hit_ff) begin
               rank_in      = RANK_W'(pos_ff) + RANK_W'(1);
               key_out_in   = sel_key_ff;
               score_out_in = IN_SCORE_W'(sel_score_ff);
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         ACT_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      count_out_in = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (commit) begin
         count_ff <= count_in;
      end
   end

   // output register: load on commit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff    <= status_in;
         rank_ff      <= rank_in;
         key_out_ff   <= key_out_in;
         score_out_ff <= score_out_in;
         notify_ff    <= notify_in;
         count_out_ff <= count_out_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.rank_out    = rank_ff;
   assign rsp_chan.key_out     = key_out_ff;
   assign rsp_chan.score_out   = score_out_ff;
   assign rsp_chan.notify      = notify_ff;
   assign rsp_chan.entry_count = count_out_ff;

endmodule

// ----- rtl/kbsrt_checker.sv -----
// Port-level checks of the ranked table, bound to the top level.
`include "keyed_best_score_ranked_table_macros.svh"

module kbsrt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input kbsrt_pkg::status_type             rsp_status,
   input logic [kbsrt_pkg::RANK_W-1:0]      rsp_rank,
   input logic [kbsrt_pkg::KEY_W-1:0]       rsp_key,
   input logic [kbsrt_pkg::IN_SCORE_W-1:0]  rsp_score,
   input logic                              rsp_notify
);
   import kbsrt_pkg::*;

   // hold a stalled result
   `KBSRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_rank) && $stable(rsp_key) && $stable(rsp_score), "stalled response changed")

   // a miss carries no rank and no notify
   `KBSRT_ASSERT_SAME(a_miss_no_rank, clock, reset, rsp_valid && rsp_status == STAT_NOT_FOUND, rsp_rank == '0 && !rsp_notify, "miss with rank or notify")

   // a dropped submit carries no rank and no notify
   `KBSRT_ASSERT_SAME(a_drop_no_rank, clock, reset, rsp_valid && rsp_status == STAT_DROPPED, rsp_rank == '0 && !rsp_notify, "drop with rank or notify")

   // notify only for a ranked, accepted entry
   `KBSRT_ASSERT_SAME(a_notify_ranked, clock, reset, rsp_valid && rsp_notify, rsp_status == STAT_OK && rsp_rank != '0, "notify without a rank")

endmodule

bind keyed_best_score_ranked_table kbsrt_checker u_kbsrt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_rank   (rsp_chan.rank_out),
   .rsp_key    (rsp_chan.key_out),
   .rsp_score  (rsp_chan.score_out),
   .rsp_notify (rsp_chan.notify)
);

// ----- verif/testbench.sv -----
// Self-checking bench for the keyed best-score ranked table: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
   import kbsrt_pkg::*;

   localparam int CAP = 64;

   typedef struct packed {
      action_type         action;
      logic [31:0]        key;
      logic signed [31:0] score;
      logic [5:0]         pos;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [6:0]         rank;
      logic [31:0]        key;
      logic signed [31:0] score;
      logic               notify;
      logic [6:0]         count;
   } rsp_type;

   typedef struct packed {
      logic          is_csr;
      csr_index_type csr_idx;
      logic [6:0]    csr_val;
      req_type       req;
      logic          typed;
      rsp_type       want;
   } dir_row_type;

   logic clock;
   logic reset;

   kbsrt_req_if req_chan ();
   kbsrt_rsp_if rsp_chan ();
   kbsrt_csr_if csr_chan ();

   keyed_best_score_ranked_table uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Shadow copy of the ranked table and its registers
   logic [31:0]        tbl_key [CAP];
   logic signed [31:0] tbl_score [CAP];
   int                 tbl_count = 0;
   bit                 cfg_hib = 1'b1;
   int                 cfg_max = 64;
   int                 cfg_notify = 0;

   rsp_type     expected_rsp_q [$];
   dir_row_type dir_rows [$];
   logic [31:0] key_pool [$];

   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Per-phase settings of the random part
   int ph_hib [4]    = '{1, 0, 1, 0};
   int ph_max [4]    = '{64, 100, 12, 64};
   int ph_notify [4] = '{5, 127, 64, 1};
   int ph_cut [4]    = '{40, 1, 3, 50};
   int ph_pool [4]   = '{80, 90, 20, 70};
   int ph_send [4]   = '{0, 80, 0, 37};
   int ph_stall [4]  = '{0, 0, 80, 37};

   function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b);
      return cfg_hib ? (a > b) : (a < b);
   endfunction

   function automatic int locate(logic [31:0] k);
      int i;
      for (i = 0; i < tbl_count; i++)
         if (tbl_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void drop_at(int idx);
      int i;
      for (i = idx; i + 1 < tbl_count; i++) begin
         tbl_key[i]   = tbl_key[i + 1];
         tbl_score[i] = tbl_score[i + 1];
      end
      tbl_count--;
   endfunction

   // Insert behind every entry that is better or equal; CAP if it falls off
   function automatic int place_sorted(logic [31:0] k, logic signed [31:0] s);
      int p;
      int i;
      p = 0;
      while (p < tbl_count && !outranks(s, tbl_score[p])) p++;
      if (p >= CAP) return CAP;
      if (tbl_count < CAP) tbl_count++;
      for (i = tbl_count - 1; i > p; i--) begin
         tbl_key[i]   = tbl_key[i - 1];
         tbl_score[i] = tbl_score[i - 1];
      end
      tbl_key[p]   = k;
      tbl_score[p] = s;
      return p;
   endfunction

   // Advance the shadow table by one request and return the result it causes
   function automatic rsp_type predict_table(req_type r);
      rsp_type o;
      int      idx;
      int      p;
      int      lim;
      bit      fresh;
      o.status = STAT_OK;
      o.rank   = '0;
      o.key    = '0;
      o.score  = '0;
      o.notify = 1'b0;
      case (r.action)
         ACT_SUBMIT: begin
            lim   = (cfg_max > CAP) ? CAP : cfg_max;
            idx   = locate(r.key);
            fresh = (idx < 0);
            if (fresh) begin
               p = place_sorted(r.key, r.score);
            end else if (outranks(r.score, tbl_score[idx])) begin
               drop_at(idx);
               p = place_sorted(r.key, r.score);
            end else begin
               p = idx;
            end
            if (tbl_count > lim) tbl_count = lim;
            o.key = r.key;
            if (p < tbl_count) begin
               o.rank   = 7'(p + 1);
               o.score  = tbl_score[p];
               o.notify = fresh && (p + 1 <= cfg_notify);
            end else begin
               o.status = STAT_DROPPED;
               o.score  = r.score;
            end
         end
         ACT_QUERY: begin
            idx   = locate(r.key);
            o.key = r.key;
            if (idx >= 0) begin
               o.rank  = 7'(idx + 1);
               o.score = tbl_score[idx];
            end else begin
               o.status = STAT_NOT_FOUND;
            end
         end
         ACT_READ: begin
            if (r.pos < tbl_count) begin
               o.rank  = 7'(r.pos) + 7'd1;
               o.key   = tbl_key[r.pos];
               o.score = tbl_score[r.pos];
            end else begin
               o.status = STAT_NOT_FOUND;
            end
         end
         default: begin
            tbl_count = 0;
         end
      endcase
      o.count = 7'(tbl_count);
      return o;
   endfunction

   function automatic logic signed [31:0] random_score();
      case ($urandom_range(9))
         0, 1, 2, 3: return $signed($urandom_range(20)) - 10;
         8:          return 32'sh7FFF_FFFF;
         9:          return 32'sh8000_0000;
         default:    return $urandom;
      endcase
   endfunction

   // Mostly submits over a key pool, with queries, reads and rare clears
   function automatic req_type random_item();
      req_type r;
      int      sel;
      int      top;
      sel     = $urandom_range(999);
      r.key   = key_pool[$urandom_range(key_pool.size() - 1)];
      r.score = random_score();
      r.pos   = 6'($urandom);
      if (sel < 4) begin
         r.action = ACT_CLEAR;
      end else if (sel < 620) begin
         r.action = ACT_SUBMIT;
         if ($urandom_range(19) == 0) r.key = $urandom;
      end else if (sel < 800) begin
         r.action = ACT_QUERY;
         if ($urandom_range(9) == 0) r.key = $urandom;
      end else begin
         r.action = ACT_READ;
         top = (tbl_count > 63) ? 63 : tbl_count;
         if ($urandom_range(9) < 7) r.pos = 6'($urandom_range(top));
      end
      return r;
   endfunction

   function automatic void add_req(action_type a, logic [31:0] k, logic signed [31:0] s,
                                   logic [5:0] p);
      dir_row_type row;
      row            = '0;
      row.req.action = a;
      row.req.key    = k;
      row.req.score  = s;
      row.req.pos    = p;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic void add_chk(action_type a, logic [31:0] k, logic signed [31:0] s,
                                   logic [5:0] p, status_type st, logic [6:0] rk,
                                   logic [31:0] ko, logic signed [31:0] so, logic nt,
                                   logic [6:0] cnt);
      add_req(a, k, s, p);
      dir_rows[$].typed       = 1'b1;
      dir_rows[$].want.status = st;
      dir_rows[$].want.rank   = rk;
      dir_rows[$].want.key    = ko;
      dir_rows[$].want.score  = so;
      dir_rows[$].want.notify = nt;
      dir_rows[$].want.count  = cnt;
   endfunction

   function automatic void add_csr(csr_index_type idx, logic [6:0] val);
      dir_row_type row;
      row         = '0;
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   // Drive one request, hold it until the transfer, then queue its expectation
   task automatic send_item(input req_type r, input logic typed, input rsp_type want);
      rsp_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= r.action;
      req_chan.player_key <= r.key;
      req_chan.new_score  <= r.score;
      req_chan.position   <= r.pos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      got = predict_table(r);
      expected_rsp_q.insert(expected_rsp_q.size(), typed ? want : got);
      items_sent++;
   endtask

   // Drop valid and hold off until every result is in and the block is quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      wait (expected_rsp_q.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [6:0] val);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wdata     <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      case (idx)
         CSR_HIGHER_IS_BETTER: cfg_hib = val[0];
         CSR_MAX_ENTRIES:      cfg_max = val;
         CSR_NOTIFY_TOP_N:     cfg_notify = val;
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic flag_mismatch(input string field, input logic [31:0] e, input logic [31:0] a);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
      errors++;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", expected_rsp_q.size());
      $display("testbench: FAIL");
      $finish;
   end

   // Check each result transfer against the oldest expectation, then pick next ready
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: result with nothing expected, key %0h", $time, rsp_chan.key_out);
               errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_chan.status !== want.status)
                  flag_mismatch("status", want.status, rsp_chan.status);
               if (rsp_chan.rank_out !== want.rank)
                  flag_mismatch("rank_out", want.rank, rsp_chan.rank_out);
               if (rsp_chan.key_out !== want.key)
                  flag_mismatch("key_out", want.key, rsp_chan.key_out);
               if (rsp_chan.score_out !== want.score)
                  flag_mismatch("score_out", want.score, rsp_chan.score_out);
               if (rsp_chan.notify !== want.notify)
                  flag_mismatch("notify", want.notify, rsp_chan.notify);
               if (rsp_chan.entry_count !== want.count)
                  flag_mismatch("entry_count", want.count, rsp_chan.entry_count);
               results_checked++;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Stimulus
   initial begin : stimulus
      int      ph;
      int      n;
      int      i;
      rsp_type none;
      req_type clr;
      none               = '0;
      clr                = '0;
      clr.action         = ACT_CLEAR;
      reset              = 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_SUBMIT;
      req_chan.player_key <= '0;
      req_chan.new_score  <= '0;
      req_chan.position   <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.reg_index  <= CSR_HIGHER_IS_BETTER;
      csr_chan.wdata      <= '0;

      // Directed table: empty table, extremes, ties, moves, trim and notify
      add_chk(ACT_READ, 32'h0, 0, 6'd0, STAT_NOT_FOUND, 0, 0, 0, 0, 0);
      add_chk(ACT_QUERY, 32'h5, 0, 6'd0, STAT_NOT_FOUND, 0, 32'h5, 0, 0, 0);
      add_chk(ACT_SUBMIT, 32'h0, 0, 6'd0, STAT_OK, 1, 32'h0, 0, 0, 1);
      add_chk(ACT_SUBMIT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 6'd0,
              STAT_OK, 1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 0, 2);
      add_chk(ACT_SUBMIT, 32'h1, 32'sh8000_0000, 6'd0,
              STAT_OK, 3, 32'h1, 32'sh8000_0000, 0, 3);
      add_req(ACT_SUBMIT, 32'h2, 0, 6'd0);
      add_req(ACT_SUBMIT, 32'h0, -5, 6'd0);
      add_req(ACT_SUBMIT, 32'h1, 100, 6'd0);
      add_req(ACT_SUBMIT, 32'h2, 0, 6'd0);
      add_req(ACT_QUERY, 32'hFFFF_FFFF, 0, 6'd0);
      add_chk(ACT_READ, 32'h0, 0, 6'd63, STAT_NOT_FOUND, 0, 0, 0, 0, 4);
      add_req(ACT_READ, 32'h0, 0, 6'd3);
      add_chk(ACT_CLEAR, 32'h0, 0, 6'd0, STAT_OK, 0, 0, 0, 0, 0);
      add_chk(ACT_READ, 32'h0, 0, 6'd0, STAT_NOT_FOUND, 0, 0, 0, 0, 0);
      add_csr(CSR_NOTIFY_TOP_N, 7'd1);
      add_chk(ACT_SUBMIT, 32'd10, 100, 6'd0, STAT_OK, 1, 32'd10, 100, 1, 1);
      add_chk(ACT_SUBMIT, 32'd11, 200, 6'd0, STAT_OK, 1, 32'd11, 200, 1, 2);
      add_chk(ACT_SUBMIT, 32'd12, 50, 6'd0, STAT_OK, 3, 32'd12, 50, 0, 3);
      // Lower the limit with entries held: reads still see the old table
      add_csr(CSR_MAX_ENTRIES, 7'd2);
      add_chk(ACT_READ, 32'h0, 0, 6'd2, STAT_OK, 3, 32'd12, 50, 0, 3);
      add_chk(ACT_SUBMIT, 32'd13, 10, 6'd0, STAT_DROPPED, 0, 32'd13, 10, 0, 2);
      add_req(ACT_SUBMIT, 32'd11, 300, 6'd0);
      add_csr(CSR_MAX_ENTRIES, 7'd0);
      add_chk(ACT_SUBMIT, 32'd14, 1, 6'd0, STAT_DROPPED, 0, 32'd14, 1, 0, 0);
      add_chk(ACT_CLEAR, 32'h0, 0, 6'd0, STAT_OK, 0, 0, 0, 0, 0);
      // Lower scores first, notify across the whole table
      add_csr(CSR_HIGHER_IS_BETTER, 7'd0);
      add_csr(CSR_MAX_ENTRIES, 7'd64);
      add_csr(CSR_NOTIFY_TOP_N, 7'd64);
      add_req(ACT_SUBMIT, 32'd20, 32'sh7FFF_FFFF, 6'd0);
      add_req(ACT_SUBMIT, 32'd21, 32'sh8000_0000, 6'd0);
      add_req(ACT_SUBMIT, 32'd20, 32'sh8000_0000, 6'd0);
      add_req(ACT_READ, 32'h0, 0, 6'd1);
      add_req(ACT_CLEAR, 32'h0, 0, 6'd0);

      // Release reset
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (i = 0; i < dir_rows.size(); i++) begin
         if (dir_rows[i].is_csr) begin
            settle();
            write_csr(dir_rows[i].csr_idx, dir_rows[i].csr_val);
         end else begin
            send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Random phases, each from a cleared table with its own settings and idle profile
      for (ph = 0; ph < 4; ph++) begin
         settle();
         send_item(clr, 1'b0, none);
         settle();
         write_csr(CSR_HIGHER_IS_BETTER, 7'(ph_hib[ph]));
         write_csr(CSR_MAX_ENTRIES, 7'(ph_max[ph]));
         write_csr(CSR_NOTIFY_TOP_N, 7'(ph_notify[ph]));
         send_idle_pct = ph_send[ph];
         rsp_stall_pct = ph_stall[ph];
         key_pool.delete();
         for (i = 0; i < ph_pool[ph]; i++) key_pool.insert(key_pool.size(), $urandom);
         for (n = 0; n < 362; n++) begin
            // Halfway: drain, then cut the limit under a populated table
            if (n == 181) begin
               settle();
               write_csr(CSR_MAX_ENTRIES, 7'(ph_cut[ph]));
            end
            send_item(random_item(), 1'b0, none);
         end
      end

      settle();
      repeat (10) @(posedge clock);
      $display("run covered %0d requests and %0d checked results over four idle profiles,",
               items_sent, results_checked);
      $display("with %0d register writes across both directions and limits 0 to 100",
               csr_writes);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/kbsrt_pkg.sv
rtl/kbsrt_req_if.sv
rtl/kbsrt_rsp_if.sv
rtl/kbsrt_csr_if.sv
rtl/kbsrt_cell.sv
rtl/keyed_best_score_ranked_table.sv
rtl/kbsrt_checker.sv
verif/testbench.sv
